/* src/arma_noise_filter_macros.svh */
// ============================================================================
// ARMA noise filter assertion macros
// Concurrent assertion shorthands shared by the filter RTL.
// ============================================================================
`ifndef ARMA_NOISE_FILTER_MACROS_SVH
`define ARMA_NOISE_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARMA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/arma_pkg.sv */
// ============================================================================
// ARMA noise filter package
// Widths, codes, item types and sequencer states of the ARMA noise filter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package arma_pkg;

    localparam int DEF_MAX_AR_ORDER = 8;
    localparam int DEF_MAX_MA_ORDER = 8;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int QUO_W      = 24;
    localparam int ORDER_W    = 4;
    localparam int COEF_IDX_W = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_AR_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MA_ORDER = 2'd1;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;
    localparam logic BANK_A      = 1'b0;
    localparam logic BANK_B      = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MA,
        ST_AR,
        ST_DRAIN,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                         mode;
        logic                         coef_bank;
        logic [COEF_IDX_W-1:0]        coef_index;
        logic signed [COEF_W-1:0]     coef_value;
        logic signed [SAMPLE_W-1:0]   excitation;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]   filtered_sample;
        logic                         saturated;
        logic                         divide_fault;
    } out_item_t;

endpackage

`default_nettype wire

/* src/arma_ram.sv */
// ============================================================================
// ARMA coefficient RAM
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module arma_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 9,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/arma_noise_filter.sv */
// ============================================================================
// ARMA noise filter
// Direct form I pole-zero filter with one shared multiplier and a serial
// divider by a0.
// ============================================================================
//
//  Channel  Ports                          Moves
//  -------  -----------------------------  ----------------------------------
//  input    s_valid s_ready s_data         coefficient load or excitation item
//  result   m_valid m_ready m_data         filtered sample item with flags
//  config   cfg_valid cfg_ready cfg_index  feedback and feedforward order writes
//           cfg_data
//
//  Load items are written in idle and can follow back to back. A sample item
//  uses one multiply per tap on the shared multiplier and a 24-step restoring
//  divider, and the next item is taken once the filter is back in idle; a zero
//  a0 or an overflowing quotient skips the divider. Reset clears the control
//  state, orders, coefficient valid bits and delay lines, but not the datapath
//  registers. The result register holds a finished item while m_ready is low;
//  the next sample item stalls in its final cycle until that register is free.
//
`timescale 1ns / 1ps
`default_nettype none
`include "arma_noise_filter_macros.svh"

module arma_noise_filter
    import arma_pkg::*;
#(
    parameter int MAX_AR_ORDER = DEF_MAX_AR_ORDER,
    parameter int MAX_MA_ORDER = DEF_MAX_MA_ORDER
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ORDER_W-1:0]   cfg_data
);

    localparam int MAX_ORDER = (MAX_AR_ORDER > MAX_MA_ORDER) ? MAX_AR_ORDER : MAX_MA_ORDER;
    localparam int CNT_W     = $clog2(MAX_ORDER + 1);
    localparam int CAA_W     = $clog2(MAX_AR_ORDER + 1);
    localparam int CAB_W     = $clog2(MAX_MA_ORDER + 1);
    localparam int DLA_W     = (MAX_AR_ORDER > 1) ? $clog2(MAX_AR_ORDER) : 1;
    localparam int DLB_W     = (MAX_MA_ORDER > 1) ? $clog2(MAX_MA_ORDER) : 1;
    localparam int IDX_W     = (CNT_W > COEF_IDX_W) ? CNT_W : COEF_IDX_W;
    localparam int ACC_W     = PROD_W + $clog2(MAX_AR_ORDER + MAX_MA_ORDER + 1);
    localparam int REM_W     = COEF_W + QUO_W;
    localparam int DIVCNT_W  = $clog2(QUO_W);
    localparam logic [QUO_W-1:0] Q_HALF = {1'b1, {(QUO_W-1){1'b0}}};

    state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIVCNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [ORDER_W-1:0] fb_ord_reg, fb_ord_next;
    logic [ORDER_W-1:0] ff_ord_reg, ff_ord_next;
    logic [CNT_W-1:0]   na, nm;

    logic [MAX_AR_ORDER:0] a_vld_reg, a_vld_next;
    logic [MAX_MA_ORDER:0] b_vld_reg, b_vld_next;

    logic signed [SAMPLE_W-1:0] yd_reg [MAX_AR_ORDER];
    logic signed [SAMPLE_W-1:0] yd_next [MAX_AR_ORDER];
    logic signed [SAMPLE_W-1:0] xd_reg [MAX_MA_ORDER];
    logic signed [SAMPLE_W-1:0] xd_next [MAX_MA_ORDER];

    logic iss_valid_reg, iss_valid_next;
    logic iss_sub_reg, iss_sub_next;
    logic iss_bank_reg, iss_bank_next;
    logic iss_a0_reg, iss_a0_next;
    logic iss_cvld_reg, iss_cvld_next;
    logic prod_valid_reg, prod_valid_next;
    logic prod_sub_reg, prod_sub_next;

    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [SAMPLE_W-1:0] opnd_reg, opnd_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [COEF_W-1:0]   a0_reg, a0_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [REM_W-1:0]           dsh_reg, dsh_next;
    logic [QUO_W-1:0]           q_reg, q_next;
    logic neg_reg, neg_next;
    logic ovf_reg, ovf_next;
    logic fault_reg, fault_next;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic s_fire, ld_fire, smp_fire, done_fire;
    logic a_we, b_we;
    logic [IDX_W-1:0] ld_idx;
    logic [CAA_W-1:0] a_waddr, a_raddr;
    logic [CAB_W-1:0] b_waddr, b_raddr;
    logic [COEF_W-1:0] a_rdata, b_rdata;
    logic [CNT_W-1:0] dl_cnt;
    logic [DLA_W-1:0] ar_dl_idx;
    logic [DLB_W-1:0] ma_dl_idx;
    logic signed [COEF_W-1:0] coef_sel;

    logic [ACC_W-1:0]  acc_abs;
    logic [COEF_W-1:0] a0_abs;
    logic              div_ge;

    logic signed [SAMPLE_W-1:0] y_val;
    logic                       y_sat;

    assign na = (32'(fb_ord_reg) > MAX_AR_ORDER) ? CNT_W'(MAX_AR_ORDER) : CNT_W'(fb_ord_reg);
    assign nm = (32'(ff_ord_reg) > MAX_MA_ORDER) ? CNT_W'(MAX_MA_ORDER) : CNT_W'(ff_ord_reg);

    arma_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_AR_ORDER + 1)
    ) u_a_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (s_data.coef_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    arma_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_MA_ORDER + 1)
    ) u_b_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (s_data.coef_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_data.mode == MODE_SAMPLE)) begin
                    state_next = ST_MA;
                end
            end
            ST_MA: begin
                if (cnt_reg == nm) begin
                    state_next = ST_AR;
                end
            end
            ST_AR: begin
                if (cnt_reg == na) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (fault_next || ovf_next) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == DIVCNT_W'(QUO_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        s_fire    = s_valid && s_ready;
        ld_fire   = s_fire && (s_data.mode == MODE_LOAD);
        smp_fire  = s_fire && (s_data.mode == MODE_SAMPLE);
        done_fire = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

        ld_idx  = IDX_W'(s_data.coef_index);
        a_waddr = ld_idx[CAA_W-1:0];
        b_waddr = ld_idx[CAB_W-1:0];
        a_we    = ld_fire && (s_data.coef_bank == BANK_A) && (ld_idx <= IDX_W'(MAX_AR_ORDER));
        b_we    = ld_fire && (s_data.coef_bank == BANK_B) && (ld_idx <= IDX_W'(MAX_MA_ORDER));
        a_raddr = cnt_reg[CAA_W-1:0];
        b_raddr = cnt_reg[CAB_W-1:0];

        dl_cnt    = (cnt_reg == '0) ? '0 : cnt_reg - 1'b1;
        ar_dl_idx = dl_cnt[DLA_W-1:0];
        ma_dl_idx = dl_cnt[DLB_W-1:0];

        iss_valid_next = 1'b0;
        iss_sub_next   = 1'b0;
        iss_bank_next  = BANK_B;
        iss_a0_next    = 1'b0;
        iss_cvld_next  = 1'b0;
        opnd_next      = opnd_reg;
        case (state_reg)
            ST_MA: begin
                iss_valid_next = 1'b1;
                iss_bank_next  = BANK_B;
                iss_cvld_next  = b_vld_reg[b_raddr];
                opnd_next      = (cnt_reg == '0) ? x_reg : xd_reg[ma_dl_idx];
            end
            ST_AR: begin
                iss_valid_next = (cnt_reg != '0);
                iss_sub_next   = 1'b1;
                iss_bank_next  = BANK_A;
                iss_a0_next    = (cnt_reg == '0);
                iss_cvld_next  = a_vld_reg[a_raddr];
                opnd_next      = yd_reg[ar_dl_idx];
            end
            default: begin
                iss_valid_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        fb_ord_next = fb_ord_reg;
        ff_ord_next = ff_ord_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_AR_ORDER: fb_ord_next = cfg_data;
                CFG_MA_ORDER: ff_ord_next = cfg_data;
                default: begin
                end
            endcase
        end

        a_vld_next = a_vld_reg;
        b_vld_next = b_vld_reg;
        if (a_we) begin
            a_vld_next[a_waddr] = 1'b1;
        end
        if (b_we) begin
            b_vld_next[b_waddr] = 1'b1;
        end

        cnt_next = '0;
        case (state_reg)
            ST_MA:    cnt_next = (cnt_reg == nm) ? '0 : cnt_reg + 1'b1;
            ST_AR:    cnt_next = (cnt_reg == na) ? '0 : cnt_reg + 1'b1;
            ST_DRAIN: cnt_next = cnt_reg + 1'b1;
            default:  cnt_next = '0;
        endcase
        div_cnt_next = (state_reg == ST_DIV) ? div_cnt_reg + 1'b1 : '0;

        x_next = smp_fire ? s_data.excitation : x_reg;

        coef_sel = '0;
        if (iss_cvld_reg) begin
            coef_sel = (iss_bank_reg == BANK_B) ? $signed(b_rdata) : $signed(a_rdata);
        end
        prod_next       = coef_sel * opnd_reg;
        prod_valid_next = iss_valid_reg;
        prod_sub_next   = iss_sub_reg;
        a0_next         = iss_a0_reg ? coef_sel : a0_reg;

        acc_next = acc_reg;
        if (smp_fire) begin
            acc_next = '0;
        end else if (prod_valid_reg) begin
            acc_next = prod_sub_reg ? acc_reg - ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end

        acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        a0_abs  = a0_reg[COEF_W-1] ? COEF_W'(-a0_reg) : COEF_W'(a0_reg);
        div_ge  = (rem_reg >= dsh_reg);

        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        fault_next = fault_reg;
        case (state_reg)
            ST_CHECK: begin
                fault_next = (a0_reg == '0);
                ovf_next   = (acc_abs >= ACC_W'({a0_abs, {QUO_W{1'b0}}}));
                neg_next   = acc_reg[ACC_W-1] ^ a0_reg[COEF_W-1];
                rem_next   = acc_abs[REM_W-1:0];
                dsh_next   = REM_W'(a0_abs) << (QUO_W - 1);
                q_next     = '0;
            end
            ST_DIV: begin
                rem_next = div_ge ? rem_reg - dsh_reg : rem_reg;
                dsh_next = dsh_reg >> 1;
                q_next   = {q_reg[QUO_W-2:0], div_ge};
            end
            default: begin
            end
        endcase

        y_val = '0;
        y_sat = 1'b0;
        if (fault_reg) begin
            y_val = '0;
        end else if (ovf_reg) begin
            y_sat = 1'b1;
            y_val = neg_reg ? SAMPLE_MIN : SAMPLE_MAX;
        end else if (neg_reg) begin
            if (q_reg > Q_HALF) begin
                y_sat = 1'b1;
                y_val = SAMPLE_MIN;
            end else begin
                y_val = $signed(-q_reg);
            end
        end else begin
            if (q_reg[QUO_W-1]) begin
                y_sat = 1'b1;
                y_val = SAMPLE_MAX;
            end else begin
                y_val = $signed(q_reg);
            end
        end

        yd_next = yd_reg;
        xd_next = xd_reg;
        if (done_fire) begin
            for (int k = 1; k < MAX_AR_ORDER; k++) begin
                yd_next[k] = yd_reg[k-1];
            end
            yd_next[0] = y_val;
            for (int k = 1; k < MAX_MA_ORDER; k++) begin
                xd_next[k] = xd_reg[k-1];
            end
            xd_next[0] = x_reg;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (done_fire) begin
            m_valid_next                = 1'b1;
            m_data_next.filtered_sample = y_val;
            m_data_next.saturated       = y_sat;
            m_data_next.divide_fault    = fault_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            div_cnt_reg    <= '0;
            fb_ord_reg     <= '0;
            ff_ord_reg     <= '0;
            a_vld_reg      <= '0;
            b_vld_reg      <= '0;
            iss_valid_reg  <= 1'b0;
            iss_sub_reg    <= 1'b0;
            iss_bank_reg   <= BANK_B;
            iss_a0_reg     <= 1'b0;
            iss_cvld_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_sub_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int k = 0; k < MAX_AR_ORDER; k++) begin
                yd_reg[k] <= '0;
            end
            for (int k = 0; k < MAX_MA_ORDER; k++) begin
                xd_reg[k] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            div_cnt_reg    <= div_cnt_next;
            fb_ord_reg     <= fb_ord_next;
            ff_ord_reg     <= ff_ord_next;
            a_vld_reg      <= a_vld_next;
            b_vld_reg      <= b_vld_next;
            iss_valid_reg  <= iss_valid_next;
            iss_sub_reg    <= iss_sub_next;
            iss_bank_reg   <= iss_bank_next;
            iss_a0_reg     <= iss_a0_next;
            iss_cvld_reg   <= iss_cvld_next;
            prod_valid_reg <= prod_valid_next;
            prod_sub_reg   <= prod_sub_next;
            m_valid_reg    <= m_valid_next;
            yd_reg         <= yd_next;
            xd_reg         <= xd_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        opnd_reg   <= opnd_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        a0_reg     <= a0_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        q_reg      <= q_next;
        neg_reg    <= neg_next;
        ovf_reg    <= ovf_next;
        fault_reg  <= fault_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ARMA_ASSERT_SAME(a_idle_pipe_empty, aclk, aresetn, s_ready,
        (!iss_valid_reg && !prod_valid_reg), "multiply pipeline busy while accepting items")
    `ARMA_ASSERT_SAME(a_div_bound, aclk, aresetn, (state_reg == ST_DIV),
        (({1'b0, rem_reg}) < ({dsh_reg, 1'b0})), "divider remainder out of range")
    `ARMA_ASSERT_NEXT(a_done_result, aclk, aresetn, done_fire,
        (m_valid && (m_data.divide_fault == $past(fault_reg))),
        "finished sample did not reach the result register")
    `ARMA_ASSERT_SAME(a_fault_zero, aclk, aresetn, (m_valid && m_data.divide_fault),
        ((m_data.filtered_sample == '0) && !m_data.saturated),
        "faulted item carries a nonzero sample")

endmodule

`default_nettype wire
